// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NPC_ASSERT_IMP(name, lhs, rhs, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication.
`define NPC_ASSERT_NEXT(name, lhs, rhs, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== rtl/core/npc_pkg.sv =====
// Shared types, widths and codes of the NAMUR sensor pulse counter.
package npc_pkg;

    localparam int NPC_SAMPLES_PER_BURST = 9;
    localparam int NPC_SAMPLE_BITS       = 10;

    localparam int SAMPLE_W   = 10;
    localparam int THRESH_W   = 10;
    localparam int BURSTS_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THRESHOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_THRESHOLD  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_THRESHOLD   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_BURSTS_PER_POWER = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [THRESH_W-1:0] SHORT_THRESHOLD_RST  = THRESH_W'(100);
    localparam logic [THRESH_W-1:0] BREAK_THRESHOLD_RST  = THRESH_W'(900);
    localparam logic [THRESH_W-1:0] DROP_THRESHOLD_RST   = THRESH_W'(50);
    localparam logic [BURSTS_W-1:0] BURSTS_PER_POWER_RST = BURSTS_W'(60);

    // Sensor status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_SHORT = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_BREAK = STATUS_W'(2);

    typedef struct packed {
        logic [THRESH_W-1:0] short_threshold;
        logic [THRESH_W-1:0] break_threshold;
        logic [THRESH_W-1:0] drop_threshold;
        logic [BURSTS_W-1:0] sensor_bursts_per_power;
    } npc_cfg_t;

endpackage

// ===== rtl/core/npc_ifs.sv =====
// Valid/ready channel interfaces: sample items, result items, register writes.
interface npc_sample_if import npc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface npc_result_if import npc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                burst_done;
    logic                next_channel;
    logic [STATUS_W-1:0] sensor_status;
    logic                pulse_seen;
    logic [COUNT_W-1:0]  pulse_total;
    logic                battery_updated;
    logic [SAMPLE_W-1:0] battery_level;

    modport source (output valid, output burst_done, output next_channel,
                    output sensor_status, output pulse_seen, output pulse_total,
                    output battery_updated, output battery_level, input ready);
    modport sink   (input valid, input burst_done, input next_channel,
                    input sensor_status, input pulse_seen, input pulse_total,
                    input battery_updated, input battery_level, output ready);
endinterface

interface npc_cfg_if import npc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/npc_cfg_regs.sv =====
// Configuration register file of the pulse counter.
module npc_cfg_regs import npc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    npc_cfg_if.sink  cfg,
    output npc_cfg_t regs
);

    npc_cfg_t regs_reg;
    npc_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SHORT_THRESHOLD:  regs_next.short_threshold = THRESH_W'(cfg.data);
                CFG_BREAK_THRESHOLD:  regs_next.break_threshold = THRESH_W'(cfg.data);
                CFG_DROP_THRESHOLD:   regs_next.drop_threshold  = THRESH_W'(cfg.data);
                CFG_BURSTS_PER_POWER: regs_next.sensor_bursts_per_power = BURSTS_W'(cfg.data);
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.short_threshold         <= SHORT_THRESHOLD_RST;
            regs_reg.break_threshold         <= BREAK_THRESHOLD_RST;
            regs_reg.drop_threshold          <= DROP_THRESHOLD_RST;
            regs_reg.sensor_bursts_per_power <= BURSTS_PER_POWER_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== rtl/core/npc_burst_core.sv =====
// Burst accumulator, averager, sensor classifier and result register.
module npc_burst_core import npc_pkg::*;
#(
    parameter int SAMPLES_PER_BURST = NPC_SAMPLES_PER_BURST,
    parameter int SAMPLE_BITS       = NPC_SAMPLE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic [SAMPLE_W-1:0] item_sample,
    output logic                item_ready,
    input  npc_cfg_t            cfg,
    npc_result_if.source        results
);

    localparam int DIV     = SAMPLES_PER_BURST - 1;
    localparam int SB_EFF  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int SUM_W   = $clog2(DIV * ((1 << SB_EFF) - 1) + 1);
    localparam int CNT_W   = $clog2(SAMPLES_PER_BURST);
    // Exact floor(sum / DIV) as (sum * RECIP) >> SHIFT for any sum below 2**SUM_W
    localparam int SHIFT   = SUM_W + $clog2(DIV);
    localparam int RECIP_W = SHIFT + 1;
    localparam longint RECIP_VAL = ((longint'(1) << SHIFT) + DIV - 1) / DIV;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [CNT_W-1:0]    LAST_IDX    = CNT_W'(DIV);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SB_EFF) - 1);

    logic [CNT_W-1:0]    samples_left_reg,  samples_left_next;
    logic [SUM_W-1:0]    running_sum_reg,   running_sum_next;
    logic [SAMPLE_W-1:0] prev_avg_reg,      prev_avg_next;
    logic [STATUS_W-1:0] status_reg,        status_next;
    logic [COUNT_W-1:0]  pulse_count_reg,   pulse_count_next;
    logic [SAMPLE_W-1:0] battery_reg,       battery_next;
    logic [BURSTS_W-1:0] bursts_left_reg,   bursts_left_next;
    logic                chan_power_reg,    chan_power_next;
    logic                out_valid_reg;
    logic                burst_done_reg,    burst_done_next;
    logic                pulse_seen_reg,    pulse_seen_next;
    logic                batt_upd_reg,      batt_upd_next;

    logic                fire;
    logic [SAMPLE_W-1:0] sample_used;
    logic [SUM_W-1:0]    sum_acc;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] fall;

    assign item_ready = !out_valid_reg || results.ready;
    assign fire       = item_valid && item_ready;

    // First sample of a burst is dropped
    assign sample_used = (samples_left_reg == LAST_IDX) ? '0 : (item_sample & SAMPLE_MASK);
    assign sum_acc     = running_sum_reg + SUM_W'(sample_used);
    assign prod        = PROD_W'(sum_acc) * PROD_W'(RECIP);
    assign avg         = SAMPLE_W'(prod >> SHIFT);
    assign fall        = prev_avg_reg - avg;

    always_comb
    begin
        samples_left_next = samples_left_reg;
        running_sum_next  = running_sum_reg;
        prev_avg_next     = prev_avg_reg;
        status_next       = status_reg;
        pulse_count_next  = pulse_count_reg;
        battery_next      = battery_reg;
        bursts_left_next  = bursts_left_reg;
        chan_power_next   = chan_power_reg;
        burst_done_next   = 1'b0;
        pulse_seen_next   = 1'b0;
        batt_upd_next     = 1'b0;

        if (samples_left_reg != '0)
        begin
            samples_left_next = samples_left_reg - CNT_W'(1);
            running_sum_next  = sum_acc;
        end
        else
        begin
            burst_done_next = 1'b1;
            if (chan_power_reg)
            begin
                battery_next  = avg;
                batt_upd_next = 1'b1;
            end
            else
            begin
                if (avg < cfg.short_threshold)
                begin
                    status_next = STATUS_SHORT;
                end
                else if (avg > cfg.break_threshold)
                begin
                    status_next = STATUS_BREAK;
                end
                else
                begin
                    status_next = STATUS_OK;
                    if ((prev_avg_reg >= avg) && (fall >= cfg.drop_threshold))
                    begin
                        pulse_count_next = pulse_count_reg + COUNT_W'(1);
                        pulse_seen_next  = 1'b1;
                    end
                end
                prev_avg_next = avg;
            end

            running_sum_next  = '0;
            samples_left_next = LAST_IDX;

            if (bursts_left_reg != '0)
            begin
                bursts_left_next = bursts_left_reg - BURSTS_W'(1);
                chan_power_next  = 1'b0;
            end
            else
            begin
                bursts_left_next = cfg.sensor_bursts_per_power;
                chan_power_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_left_reg <= LAST_IDX;
            running_sum_reg  <= '0;
            prev_avg_reg     <= '0;
            status_reg       <= STATUS_OK;
            pulse_count_reg  <= '0;
            battery_reg      <= '0;
            bursts_left_reg  <= '0;
            chan_power_reg   <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                samples_left_reg <= samples_left_next;
                running_sum_reg  <= running_sum_next;
                prev_avg_reg     <= prev_avg_next;
                status_reg       <= status_next;
                pulse_count_reg  <= pulse_count_next;
                battery_reg      <= battery_next;
                bursts_left_reg  <= bursts_left_next;
                chan_power_reg   <= chan_power_next;
                out_valid_reg    <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            burst_done_reg <= burst_done_next;
            pulse_seen_reg <= pulse_seen_next;
            batt_upd_reg   <= batt_upd_next;
        end
    end

    // State only moves when a new result is loaded, so it matches the held item
    assign results.valid           = out_valid_reg;
    assign results.burst_done      = burst_done_reg;
    assign results.next_channel    = chan_power_reg;
    assign results.sensor_status   = status_reg;
    assign results.pulse_seen      = pulse_seen_reg;
    assign results.pulse_total     = pulse_count_reg;
    assign results.battery_updated = batt_upd_reg;
    assign results.battery_level   = battery_reg;

endmodule

// ===== rtl/core/namur_sensor_pulse_counter.sv =====
// NAMUR sensor pulse counter: sample input register, burst core, config registers.
// Usage:
//   samples: one ADC sample item per handshake, for the channel last reported
//     in next_channel (0 sensor, 1 battery; battery right after reset).
//   results: exactly one result item per sample item. burst_done marks the
//     sample that closed a burst; pulse_seen and battery_updated say what the
//     burst did; the other fields always show the current held values.
//   cfg: register writes (0 short, 1 break, 2 drop, 3 sensor bursts per
//     battery burst), always ready; the user must write only while the block is idle (not enforced).
// A sample passes through one input register, then the accumulate /
// constant-reciprocal average / classify stage that loads the result register.
// Throughput is one item per cycle while the receiver does not stall.
// If the receiver stalls, the result register holds, the input register fills
// and then samples.ready drops; nothing is lost.
// Reset (async, active low) empties both registers, restarts the burst and
// clears counts, averages and status; config returns to its defaults.
`include "assert_macros.svh"

module namur_sensor_pulse_counter import npc_pkg::*;
#(
    parameter int SAMPLES_PER_BURST = NPC_SAMPLES_PER_BURST,
    parameter int SAMPLE_BITS       = NPC_SAMPLE_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    npc_sample_if.sink   samples,
    npc_result_if.source results,
    npc_cfg_if.sink      cfg
);

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                core_ready;
    npc_cfg_t            cfg_regs;

    assign samples.ready = !s1_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_sample_reg <= samples.sample;
        end
    end

    npc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    npc_burst_core #(
        .SAMPLES_PER_BURST (SAMPLES_PER_BURST),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s1_valid_reg),
        .item_sample (s1_sample_reg),
        .item_ready  (core_ready),
        .cfg         (cfg_regs),
        .results     (results)
    );

    `NPC_ASSERT_IMP(a_batt_needs_burst, results.valid && results.battery_updated,
        results.burst_done && !results.pulse_seen, "battery update outside burst end")
    `NPC_ASSERT_IMP(a_pulse_needs_ok, results.valid && results.pulse_seen,
        results.burst_done && (results.sensor_status == STATUS_OK), "pulse on bad sensor")
    `NPC_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !core_ready,
        s1_valid_reg && $stable(s1_sample_reg), "input register lost a stalled item")

endmodule

// ===== dv/testbench.sv =====
// Testbench for the NAMUR sensor pulse counter: burst stimulus, scoreboard and checks.
module testbench;
    import npc_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int BURST_LEN      = NPC_SAMPLES_PER_BURST;
    localparam int SUM_W          = SAMPLE_W + $clog2(BURST_LEN - 1);
    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
    localparam int MAX_IDLE       = 18;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 45;
    localparam int TIMEOUT_CYCLES = 200000;

    localparam logic [3:0]           LAST_SLOT  = 4'(BURST_LEN - 1);
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = CFG_BURSTS_PER_POWER + 1'b1;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP    = '1;

    typedef struct packed {
        logic                burst_done;
        logic                next_channel;
        logic [STATUS_W-1:0] sensor_status;
        logic                pulse_seen;
        logic [COUNT_W-1:0]  pulse_total;
        logic                battery_updated;
        logic [SAMPLE_W-1:0] battery_level;
    } meter_result_t;

    class meter_scoreboard;
        npc_cfg_t            regs;
        logic [3:0]          samples_left;
        logic [SUM_W-1:0]    burst_sum;
        logic [SAMPLE_W-1:0] prev_avg;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  pulses;
        logic [SAMPLE_W-1:0] battery;
        logic [BURSTS_W-1:0] until_battery;
        logic                on_battery;
        meter_result_t       pending_results[$];
        int                  errors;

        function new();
            regs.short_threshold         = SHORT_THRESHOLD_RST;
            regs.break_threshold         = BREAK_THRESHOLD_RST;
            regs.drop_threshold          = DROP_THRESHOLD_RST;
            regs.sensor_bursts_per_power = BURSTS_PER_POWER_RST;
            samples_left  = LAST_SLOT;
            burst_sum     = '0;
            prev_avg      = '0;
            status        = STATUS_OK;
            pulses        = '0;
            battery       = '0;
            until_battery = '0;
            on_battery    = 1'b1;
            errors        = 0;
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SHORT_THRESHOLD:  regs.short_threshold = data[THRESH_W-1:0];
                CFG_BREAK_THRESHOLD:  regs.break_threshold = data[THRESH_W-1:0];
                CFG_DROP_THRESHOLD:   regs.drop_threshold = data[THRESH_W-1:0];
                CFG_BURSTS_PER_POWER: regs.sensor_bursts_per_power = data[BURSTS_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances the burst state by one sample item and queues the result it causes.
        function void accept_sample(logic [SAMPLE_W-1:0] s);
            meter_result_t       r;
            logic [SAMPLE_W-1:0] avg;
            r = '0;
            // first sample of a burst is dropped
            if (samples_left < LAST_SLOT)
                burst_sum = burst_sum + SUM_W'(s);
            if (samples_left != 0)
                samples_left = samples_left - 1'b1;
            else
            begin
                avg = SAMPLE_W'(burst_sum / (BURST_LEN - 1));
                r.burst_done = 1'b1;
                if (on_battery)
                begin
                    battery = avg;
                    r.battery_updated = 1'b1;
                end
                else
                begin
                    if (avg < regs.short_threshold)
                        status = STATUS_SHORT;
                    else if (avg > regs.break_threshold)
                        status = STATUS_BREAK;
                    else
                    begin
                        if (prev_avg >= avg && (prev_avg - avg) >= regs.drop_threshold)
                        begin
                            pulses = pulses + 1'b1;
                            r.pulse_seen = 1'b1;
                        end
                        status = STATUS_OK;
                    end
                    prev_avg = avg;
                end
                burst_sum    = '0;
                samples_left = LAST_SLOT;
                if (until_battery != 0)
                begin
                    until_battery = until_battery - 1'b1;
                    on_battery    = 1'b0;
                end
                else
                begin
                    on_battery    = 1'b1;
                    until_battery = regs.sensor_bursts_per_power;
                end
            end
            r.next_channel  = on_battery;
            r.sensor_status = status;
            r.pulse_total   = pulses;
            r.battery_level = battery;
            pending_results.push_back(r);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(meter_result_t got);
            meter_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result item, pulse_total %0h", got.pulse_total));
                return;
            end
            want = pending_results.pop_front();
            check_field("burst_done", got.burst_done, want.burst_done);
            check_field("next_channel", got.next_channel, want.next_channel);
            check_field("sensor_status", got.sensor_status, want.sensor_status);
            check_field("pulse_seen", got.pulse_seen, want.pulse_seen);
            check_field("pulse_total", got.pulse_total, want.pulse_total);
            check_field("battery_updated", got.battery_updated, want.battery_updated);
            check_field("battery_level", got.battery_level, want.battery_level);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    npc_sample_if samples_ch ();
    npc_result_if results_ch ();
    npc_cfg_if    cfg_ch ();

    namur_sensor_pulse_counter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    meter_scoreboard meter;
    bit              steady;
    int              last_level;

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic int clip(int v);
        return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            samples_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid  = 1'b1;
        samples_ch.sample = s;
        do @(posedge clk); while (!samples_ch.ready);
        meter.accept_sample(s);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge clk); while (!cfg_ch.ready);
        meter.apply_write(idx, data);
        @(negedge clk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] short_lim,
                              input logic [CFG_DATA_W-1:0] break_lim,
                              input logic [CFG_DATA_W-1:0] drop_lim,
                              input logic [CFG_DATA_W-1:0] sensor_runs);
        write_register(CFG_SHORT_THRESHOLD, short_lim);
        write_register(CFG_BREAK_THRESHOLD, break_lim);
        write_register(CFG_DROP_THRESHOLD, drop_lim);
        write_register(CFG_BURSTS_PER_POWER, sensor_runs);
    endtask

    task automatic wait_idle();
        samples_ch.valid = 1'b0;
        while (meter.pending() != 0) @(negedge clk);
    endtask

    // Burst level aimed at one branch of the sensor classification.
    function automatic int pick_level();
        int s_lim;
        int b_lim;
        int lvl;
        s_lim = int'(meter.regs.short_threshold);
        b_lim = int'(meter.regs.break_threshold);
        case ($urandom_range(0, 5))
            0: lvl = (s_lim == 0) ? 0 : $urandom_range(0, s_lim - 1);
            1: lvl = (b_lim >= SAMPLE_MAX) ? SAMPLE_MAX : $urandom_range(b_lim + 1, SAMPLE_MAX);
            2: lvl = last_level - int'(meter.regs.drop_threshold) - $urandom_range(0, 20);
            3: lvl = last_level;
            4: lvl = last_level + $urandom_range(0, 100);
            default: lvl = $urandom_range(0, SAMPLE_MAX);
        endcase
        last_level = clip(lvl);
        return last_level;
    endfunction

    task automatic send_burst(input int level);
        for (int i = 0; i < BURST_LEN; i++)
        begin
            if (i == 0 || $urandom_range(0, 9) == 0)
                send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
            else
                send_sample(SAMPLE_W'(clip(level + $urandom_range(0, 6) - 3)));
        end
    endtask

    initial
    begin
        int sent;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        steady            = 1'b0;
        last_level        = 0;
        meter = new();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // two battery bursts after reset: full scale, then zero; then a broken sensor line
        send_sample('0);
        repeat (BURST_LEN - 1) send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        repeat (BURST_LEN - 1) send_sample('0);
        send_sample('0);
        repeat (BURST_LEN - 1) send_sample(SAMPLE_W'(SAMPLE_MAX));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0: set_limits(10'd100, 10'd900, 10'd50, 10'd2);
                1: set_limits(10'd0, 10'd1023, 10'd0, 10'd255);
                2: set_limits(10'd1023, 10'd0, 10'd1023, 10'd0);
                3: set_limits(10'd300, 10'd700, 10'd1, 10'd5);
                default:
                begin
                    set_limits(CFG_DATA_W'($urandom_range(0, 400)),
                               CFG_DATA_W'($urandom_range(500, SAMPLE_MAX)),
                               CFG_DATA_W'($urandom_range(0, SAMPLE_MAX)),
                               {2'($urandom), 8'($urandom_range(0, 6))});
                    // writes past the register list must leave every register alone
                    write_register(IDX_UNUSED, CFG_DATA_W'($urandom));
                    write_register(IDX_TOP, '1);
                end
            endcase
            cfg_ch.valid = 1'b0;
            steady = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    // stray item shifts the burst alignment
                    send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
                    sent++;
                end
                else
                begin
                    send_burst(pick_level());
                    sent += BURST_LEN;
                end
            end
        end

        wait_idle();
        repeat (4) @(negedge clk);
        if (meter.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result sink with random stalls.
    initial
    begin
        meter_result_t got;
        int            gap;
        results_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                results_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            results_ch.ready = 1'b1;
            do @(posedge clk); while (!results_ch.valid);
            got = {results_ch.burst_done, results_ch.next_channel, results_ch.sensor_status,
                   results_ch.pulse_seen, results_ch.pulse_total, results_ch.battery_updated,
                   results_ch.battery_level};
            meter.check_result(got);
            @(negedge clk);
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

endmodule
